@@ rtl/wta_pkg.sv @@
// ---------------------------------------------------------------------------
// wta_pkg: shared types and constants of the wavetable oscillator
// Register indexes, sequencer states, datapath control and the arpeggio
// step wrap helper.
// ---------------------------------------------------------------------------
`default_nettype none

package wta_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TABLE_AW    = 10;
    localparam int WORD_W      = 16;
    localparam int STEP_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MASK     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DURATION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_DEPTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_FACTORS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_SHIFTS  = 3'd6;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_MUL2 = 5'b00100,
        S_MUL3 = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    typedef struct packed {
        logic ld_prod1;
        logic ld_incr;
        logic ld_prod2;
    } incr_ctl_t;

    // (val mod len) for val <= 8 and 1 <= len <= 8
    function automatic logic [STEP_W-1:0] step_wrap(input logic [3:0] val,
                                                    input logic [3:0] len);
        logic [3:0] r;
        r = val;
        for (int i = 0; i < 8; i++) begin
            if (r >= len) begin
                r = r - len;
            end
        end
        return r[STEP_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/wta_ram.sv @@
// ---------------------------------------------------------------------------
// wta_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module wta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/wta_incr.sv @@
// ---------------------------------------------------------------------------
// wta_incr: phase increment datapath
// Three registered multiply steps: lfo times coarse phase step, times vibrato
// depth (plus base step), times arpeggio factor, then the step's right shift.
// ---------------------------------------------------------------------------
`default_nettype none

module wta_incr (
    input  wire logic               clk,
    input  wire wta_pkg::incr_ctl_t ctl,
    input  wire logic signed [15:0] lfo,
    input  wire logic [31:0]        phase_step,
    input  wire logic [7:0]         depth,
    input  wire logic [7:0]         factor,
    input  wire logic [3:0]         shift,
    output logic [31:0]             incr
);

    logic signed [28:0] lfo_ext;
    logic signed [28:0] coarse_ext;
    logic signed [28:0] prod1_next;
    logic signed [28:0] prod1_reg;
    logic [31:0]        prod1_32;
    logic [31:0]        vib_raw;
    logic [31:0]        vib;
    logic [31:0]        incr_next;
    logic [31:0]        incr_reg;
    logic [31:0]        prod2_next;
    logic [31:0]        prod2_reg;

    assign lfo_ext    = 29'(lfo);
    assign coarse_ext = 29'({1'b0, phase_step[31:20]});
    assign prod1_next = lfo_ext * coarse_ext;

    // low 32 bits of the product do not depend on operand signedness
    assign prod1_32   = 32'(prod1_reg);
    assign vib_raw    = prod1_32 * {24'b0, depth};
    assign vib        = 32'($signed(vib_raw) >>> 8);
    assign incr_next  = phase_step + vib;
    assign prod2_next = incr_reg * {24'b0, factor};

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod1)
        begin
            prod1_reg <= prod1_next;
        end
        if (ctl.ld_incr)
        begin
            incr_reg <= incr_next;
        end
        if (ctl.ld_prod2)
        begin
            prod2_reg <= prod2_next;
        end
    end

    assign incr = prod2_reg >> shift;

endmodule

`default_nettype wire

@@ rtl/wavetable_oscillator_arpeggio_top.sv @@
// ---------------------------------------------------------------------------
// wavetable_oscillator_arpeggio_top: wavetable oscillator with arpeggiator
// Table write items are accepted in S_IDLE and leave the sequencer there. A
// sample item is read from the table at the accepting edge; S_MUL1, S_MUL2
// and S_MUL3 hold the chained multiplies of the increment, and S_DONE updates
// the phase and loads the result. Input is ready again only once the
// sequencer is back in S_IDLE, so a sample item is not accepted before the
// last one has loaded its result; a waiting result holds the sequencer in its
// final state. Output register lets the next item enter while a result waits.
// Reset (async, active low) clears phase, tick, step and control state and
// loads register defaults; the wavetable is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module wavetable_oscillator_arpeggio_top #(
    parameter int PHASE_SHIFT = 22,
    parameter int MAX_STEPS   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // lfo_value[15:0], table_index[25:16], table_value[41:26], zero pad
    input  wire logic [47:0] s_axis_tdata,
    // opcode
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sample_out[15:0], current_step[18:16], zero pad
    output logic [23:0]      m_axis_tdata
);

    wta_pkg::state_t    state_reg, state_next;
    wta_pkg::incr_ctl_t incr_ctl;

    logic [31:0] phase_step_reg;
    logic [15:0] sample_mask_reg;
    logic [15:0] step_duration_reg;
    logic [7:0]  vibrato_depth_reg;
    logic [3:0]  pattern_length_reg;
    logic [63:0] pattern_factors_reg;
    logic [31:0] pattern_shifts_reg;

    logic [31:0] phase_acc_reg, phase_acc_next;
    logic [15:0] tick_reg, tick_next, tick_inc;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  eff_len;

    logic signed [15:0] lfo_reg;
    logic signed [15:0] in_lfo;
    logic [9:0]         in_index;
    logic [15:0]        in_value;
    logic               in_acc;
    logic               acc_sample;
    logic               acc_write;

    logic [9:0]  rd_addr;
    logic [15:0] rd_word;
    logic [7:0]  factor;
    logic [3:0]  shift;
    logic [31:0] incr;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_sample_reg;
    logic [2:0]  out_step_reg;
    logic        out_load;

    assign in_lfo     = $signed(s_axis_tdata[15:0]);
    assign in_index   = s_axis_tdata[25:16];
    assign in_value   = s_axis_tdata[41:26];
    assign s_axis_tready = (state_reg == wta_pkg::S_IDLE);
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign acc_sample = in_acc && (s_axis_tuser == wta_pkg::OP_SAMPLE);
    assign acc_write  = in_acc && (s_axis_tuser == wta_pkg::OP_WRITE);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg      <= 32'd0;
            sample_mask_reg     <= 16'hFFFF;
            step_duration_reg   <= 16'd44100;
            vibrato_depth_reg   <= 8'd0;
            pattern_length_reg  <= 4'd1;
            pattern_factors_reg <= 64'd1;
            pattern_shifts_reg  <= 32'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wta_pkg::REG_PHASE_STEP:      phase_step_reg      <= cfg_wr_data[31:0];
                wta_pkg::REG_SAMPLE_MASK:     sample_mask_reg     <= cfg_wr_data[15:0];
                wta_pkg::REG_STEP_DURATION:   step_duration_reg   <= cfg_wr_data[15:0];
                wta_pkg::REG_VIBRATO_DEPTH:   vibrato_depth_reg   <= cfg_wr_data[7:0];
                wta_pkg::REG_PATTERN_LENGTH:  pattern_length_reg  <= cfg_wr_data[3:0];
                wta_pkg::REG_PATTERN_FACTORS: pattern_factors_reg <= cfg_wr_data;
                wta_pkg::REG_PATTERN_SHIFTS:  pattern_shifts_reg  <= cfg_wr_data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- arpeggio tick and step ----------------
    always_comb
    begin
        if (pattern_length_reg == 4'd0)
        begin
            eff_len = 4'd1;
        end
        else if (pattern_length_reg > 4'(MAX_STEPS))
        begin
            eff_len = 4'(MAX_STEPS);
        end
        else
        begin
            eff_len = pattern_length_reg;
        end
    end

    assign tick_inc = tick_reg + 16'd1;

    always_comb
    begin
        tick_next = tick_reg;
        step_next = step_reg;
        if (acc_sample)
        begin
            if (tick_inc >= step_duration_reg)
            begin
                tick_next = 16'd0;
                step_next = wta_pkg::step_wrap({1'b0, step_reg} + 4'd1, eff_len);
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    assign factor = pattern_factors_reg[{step_reg, 3'b000} +: 8];
    assign shift  = pattern_shifts_reg[{step_reg, 2'b00} +: 4];

    // ---------------- wavetable ----------------
    assign rd_addr = 10'(phase_acc_reg >> PHASE_SHIFT);

    wta_ram #(
        .WIDTH (wta_pkg::WORD_W),
        .DEPTH (wta_pkg::TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (acc_write),
        .wr_addr (in_index),
        .wr_data (in_value),
        .rd_en   (acc_sample),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // ---------------- increment datapath ----------------
    assign incr_ctl.ld_prod1 = (state_reg == wta_pkg::S_MUL1);
    assign incr_ctl.ld_incr  = (state_reg == wta_pkg::S_MUL2);
    assign incr_ctl.ld_prod2 = (state_reg == wta_pkg::S_MUL3);

    wta_incr u_incr (
        .clk        (clk),
        .ctl        (incr_ctl),
        .lfo        (lfo_reg),
        .phase_step (phase_step_reg),
        .depth      (vibrato_depth_reg),
        .factor     (factor),
        .shift      (shift),
        .incr       (incr)
    );

    // ---------------- sequencer ----------------
    // result leaves through the output register; phase advances with it
    assign out_load = (state_reg == wta_pkg::S_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wta_pkg::S_IDLE: if (acc_sample) state_next = wta_pkg::S_MUL1;
            wta_pkg::S_MUL1: state_next = wta_pkg::S_MUL2;
            wta_pkg::S_MUL2: state_next = wta_pkg::S_MUL3;
            wta_pkg::S_MUL3: state_next = wta_pkg::S_DONE;
            wta_pkg::S_DONE: if (out_load) state_next = wta_pkg::S_IDLE;
            default:         state_next = wta_pkg::S_IDLE;
        endcase
    end

    assign phase_acc_next = out_load ? (phase_acc_reg + incr) : phase_acc_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wta_pkg::S_IDLE;
            phase_acc_reg <= 32'd0;
            tick_reg      <= 16'd0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_acc_reg <= phase_acc_next;
            tick_reg      <= tick_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_sample)
        begin
            lfo_reg <= in_lfo;
        end
        if (out_load)
        begin
            out_sample_reg <= rd_word & sample_mask_reg;
            out_step_reg   <= step_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_step_reg, out_sample_reg};

    // ---------------- assertions ----------------
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        acc_sample |=> state_reg == wta_pkg::S_MUL1)
        else $error("sample item did not start the multiply sequence");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wta_pkg::S_DONE))
        else $error("result loaded outside the final state");

    a_phase_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(phase_acc_reg) |-> $past(out_load))
        else $error("phase changed without a delivered result");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        acc_sample |=> {1'b0, step_reg} < $past(eff_len)
                       || $past(step_reg) == step_reg)
        else $error("arpeggio step outside the pattern");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb: testbench for the wavetable oscillator with arpeggiator
// Drives table writes and sample items over the input stream, predicts every
// sample and arpeggio step from a local copy of the phase, tick, step, table
// and registers, and checks each output item in order. A short directed table
// comes first, then randomized phases with changing register settings and
// random idling and stalls on both streams.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int PHASE_SHIFT  = 22;
    localparam int MAX_STEPS    = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 160;

    localparam logic OP_SAMPLE = wta_pkg::OP_SAMPLE;
    localparam logic OP_WRITE  = wta_pkg::OP_WRITE;

    localparam logic [2:0] REG_PHASE_STEP      = wta_pkg::REG_PHASE_STEP;
    localparam logic [2:0] REG_SAMPLE_MASK     = wta_pkg::REG_SAMPLE_MASK;
    localparam logic [2:0] REG_STEP_DURATION   = wta_pkg::REG_STEP_DURATION;
    localparam logic [2:0] REG_VIBRATO_DEPTH   = wta_pkg::REG_VIBRATO_DEPTH;
    localparam logic [2:0] REG_PATTERN_LENGTH  = wta_pkg::REG_PATTERN_LENGTH;
    localparam logic [2:0] REG_PATTERN_FACTORS = wta_pkg::REG_PATTERN_FACTORS;
    localparam logic [2:0] REG_PATTERN_SHIFTS  = wta_pkg::REG_PATTERN_SHIFTS;

    typedef struct packed {
        logic [15:0] sample;
        logic [2:0]  step;
    } osc_out_t;

    typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [63:0] reg_val;
        logic        op;
        logic [15:0] lfo;
        logic [9:0]  idx;
        logic [15:0] word;
        logic        typed;
        osc_out_t    want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    // local copy of the oscillator registers and state
    logic [31:0] phase_step;
    logic [15:0] sample_mask;
    logic [15:0] step_duration;
    logic [7:0]  vibrato_depth;
    logic [3:0]  pattern_length;
    logic [63:0] pattern_factors;
    logic [31:0] pattern_shifts;
    logic [31:0] phase_acc;
    logic [15:0] tick_count;
    logic [2:0]  step_index;
    logic [15:0] wave [0:1023];
    bit          filled [0:1023];

    osc_out_t    samples_due [$];
    osc_out_t    head;
    plan_row_t   plan [$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet;
    bit          hold_req;

    wavetable_oscillator_arpeggio_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // one sample item: tick, arpeggio step, table read, phase advance
    function automatic osc_out_t next_sample(input logic [15:0] lfo);
        osc_out_t           res;
        int                 len;
        logic [31:0]        lfo32;
        logic [31:0]        prod;
        logic signed [31:0] sprod;
        logic [31:0]        vib;
        logic [31:0]        factor;
        logic [3:0]         shamt;
        tick_count = tick_count + 16'd1;
        if (tick_count >= step_duration)
        begin
            len = (pattern_length == 4'd0) ? 1 : int'(pattern_length);
            if (len > MAX_STEPS)
            begin
                len = MAX_STEPS;
            end
            step_index = 3'((int'(step_index) + 1) % len);
            tick_count = 16'd0;
        end
        res.sample = wave[10'(phase_acc >> PHASE_SHIFT)] & sample_mask;
        res.step   = step_index;
        lfo32  = {{16{lfo[15]}}, lfo};
        prod   = lfo32 * {12'd0, phase_step[31:20]} * {24'd0, vibrato_depth};
        sprod  = prod;
        vib    = sprod >>> 8;
        factor = {24'd0, pattern_factors[8*step_index +: 8]};
        shamt  = pattern_shifts[4*step_index +: 4];
        phase_acc = phase_acc + (((phase_step + vib) * factor) >> shamt);
        return res;
    endfunction

    function automatic plan_row_t reg_row(input logic [2:0] idx, input logic [63:0] val);
        plan_row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic op, input logic [15:0] lfo,
                                           input logic [9:0] idx, input logic [15:0] word,
                                           input logic typed, input logic [15:0] want_sample,
                                           input logic [2:0] want_step);
        plan_row_t r;
        r = '0;
        r.kind        = ROW_ITEM;
        r.op          = op;
        r.lfo         = lfo;
        r.idx         = idx;
        r.word        = word;
        r.typed       = typed;
        r.want.sample = want_sample;
        r.want.step   = want_step;
        return r;
    endfunction

    task automatic offer(input logic op, input logic [15:0] lfo, input logic [9:0] idx,
                         input logic [15:0] word, input logic typed, input osc_out_t want);
        osc_out_t got;
        while (!quiet && $urandom_range(99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, word, idx, lfo};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (op == OP_WRITE)
        begin
            wave[idx]   = word;
            filled[idx] = 1'b1;
        end
        else
        begin
            got = next_sample(lfo);
            samples_due.push_back(typed ? want : got);
        end
    endtask

    // a sample never reads a table entry that was never written
    task automatic send_item(input logic op, input logic [15:0] lfo, input logic [9:0] idx,
                             input logic [15:0] word, input logic typed, input osc_out_t want);
        logic [9:0] rd;
        rd = 10'(phase_acc >> PHASE_SHIFT);
        if (op == OP_SAMPLE && !filled[rd])
        begin
            offer(OP_WRITE, 16'($urandom), rd, 16'($urandom), 1'b0, '0);
        end
        offer(op, lfo, idx, word, typed, want);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (samples_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        case (idx)
            REG_PHASE_STEP:      phase_step      = val[31:0];
            REG_SAMPLE_MASK:     sample_mask     = val[15:0];
            REG_STEP_DURATION:   step_duration   = val[15:0];
            REG_VIBRATO_DEPTH:   vibrato_depth   = val[7:0];
            REG_PATTERN_LENGTH:  pattern_length  = val[3:0];
            REG_PATTERN_FACTORS: pattern_factors = val;
            REG_PATTERN_SHIFTS:  pattern_shifts  = val[31:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] inc, input logic [15:0] mask,
                             input logic [15:0] dur, input logic [7:0] depth,
                             input logic [3:0] len, input logic [63:0] factors,
                             input logic [31:0] shifts);
        write_reg(REG_PHASE_STEP, {32'd0, inc});
        write_reg(REG_SAMPLE_MASK, {48'd0, mask});
        write_reg(REG_STEP_DURATION, {48'd0, dur});
        write_reg(REG_VIBRATO_DEPTH, {56'd0, depth});
        write_reg(REG_PATTERN_LENGTH, {60'd0, len});
        write_reg(REG_PATTERN_FACTORS, factors);
        write_reg(REG_PATTERN_SHIFTS, {32'd0, shifts});
    endtask

    // output side: random stalls, plus one long hold when asked
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (samples_due.size() == 0)
            begin
                $display("%0t: unexpected item, tdata %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                head = samples_due.pop_front();
                if (m_axis_tdata[15:0] !== head.sample)
                begin
                    $display("%0t: sample_out expected %h actual %h",
                             $time, head.sample, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[18:16] !== head.step)
                begin
                    $display("%0t: current_step expected %0d actual %0d",
                             $time, head.step, m_axis_tdata[18:16]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int       p;
        int       n;
        logic     op;
        osc_out_t none;
        none            = '0;
        quiet           = 1'b0;
        hold_req        = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_PHASE_STEP;
        cfg_wr_data     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_SAMPLE;
        phase_step      = 32'd0;
        sample_mask     = 16'hFFFF;
        step_duration   = 16'd44100;
        vibrato_depth   = 8'd0;
        pattern_length  = 4'd1;
        pattern_factors = 64'd1;
        pattern_shifts  = 32'd0;
        phase_acc       = 32'd0;
        tick_count      = 16'd0;
        step_index      = 3'd0;
        for (int i = 0; i < 1024; i++)
        begin
            wave[i]   = 16'd0;
            filled[i] = 1'b0;
        end

        // defaults after reset, extreme words and masks, length and duration corners
        plan.push_back(item_row(OP_WRITE, 16'h0000, 10'd0, 16'h7FFF, 1'b0, 16'h0, 3'd0));
        plan.push_back(item_row(OP_SAMPLE, 16'h7FFF, 10'd0, 16'h0, 1'b1, 16'h7FFF, 3'd0));
        plan.push_back(item_row(OP_WRITE, 16'hFFFF, 10'd0, 16'h8000, 1'b0, 16'h0, 3'd0));
        plan.push_back(item_row(OP_SAMPLE, 16'h8000, 10'h3FF, 16'hFFFF, 1'b1, 16'h8000, 3'd0));
        plan.push_back(item_row(OP_WRITE, 16'h8000, 10'h3FF, 16'hFFFF, 1'b0, 16'h0, 3'd0));
        plan.push_back(reg_row(REG_SAMPLE_MASK, 64'h00F0));
        plan.push_back(item_row(OP_SAMPLE, 16'h0000, 10'd0, 16'h0, 1'b1, 16'h0000, 3'd0));
        plan.push_back(reg_row(REG_SAMPLE_MASK, 64'h0000));
        plan.push_back(item_row(OP_WRITE, 16'h0000, 10'd0, 16'h7FFF, 1'b0, 16'h0, 3'd0));
        plan.push_back(item_row(OP_SAMPLE, 16'h1234, 10'd0, 16'h0, 1'b1, 16'h0000, 3'd0));
        plan.push_back(reg_row(REG_SAMPLE_MASK, 64'hFFFF));
        plan.push_back(reg_row(REG_STEP_DURATION, 64'd0));
        plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'd0));
        // zero length acts as one step
        plan.push_back(item_row(OP_SAMPLE, 16'h0001, 10'd0, 16'h0, 1'b1, 16'h7FFF, 3'd0));
        // length above eight saturates
        plan.push_back(reg_row(REG_PATTERN_LENGTH, 64'd15));
        plan.push_back(item_row(OP_SAMPLE, 16'h0000, 10'd0, 16'h0, 1'b1, 16'h7FFF, 3'd1));
        plan.push_back(item_row(OP_SAMPLE, 16'h0000, 10'd0, 16'h0, 1'b1, 16'h7FFF, 3'd2));
        plan.push_back(reg_row(REG_PATTERN_FACTORS, 64'h0101_0101_0101_0101));
        plan.push_back(reg_row(REG_PHASE_STEP, 64'hFFC0_0000));
        plan.push_back(item_row(OP_SAMPLE, 16'h0000, 10'd0, 16'h0, 1'b0, 16'h0, 3'd0));
        plan.push_back(item_row(OP_SAMPLE, 16'h0000, 10'd0, 16'h0, 1'b0, 16'h0, 3'd0));
        plan.push_back(reg_row(REG_VIBRATO_DEPTH, 64'd255));
        plan.push_back(reg_row(REG_PHASE_STEP, 64'hFFFF_FFFF));
        plan.push_back(reg_row(REG_PATTERN_SHIFTS, 64'hFEDC_BA98));
        plan.push_back(item_row(OP_SAMPLE, 16'h8000, 10'd0, 16'h0, 1'b0, 16'h0, 3'd0));
        plan.push_back(item_row(OP_SAMPLE, 16'h7FFF, 10'd0, 16'h0, 1'b0, 16'h0, 3'd0));
        plan.push_back(item_row(OP_SAMPLE, 16'hFFFF, 10'd0, 16'h0, 1'b0, 16'h0, 3'd0));
        plan.push_back(reg_row(REG_STEP_DURATION, 64'd65535));
        plan.push_back(reg_row(REG_PATTERN_FACTORS, 64'hFFFF_FFFF_FFFF_FFFF));
        plan.push_back(item_row(OP_SAMPLE, 16'h4000, 10'd0, 16'h0, 1'b0, 16'h0, 3'd0));
        plan.push_back(item_row(OP_SAMPLE, 16'hC000, 10'd0, 16'h0, 1'b0, 16'h0, 3'd0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_item(plan[i].op, plan[i].lfo, plan[i].idx, plan[i].word,
                          plan[i].typed, plan[i].want);
            end
        end

        for (p = 0; p < RAND_PHASES; p++)
        begin
            settle();
            if (p == 0)
            begin
                write_all(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd8,
                          64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
            end
            else if (p == 1)
            begin
                write_all(32'd0, 16'd0, 16'd0, 8'd0, 4'd1, 64'd0, 32'd0);
            end
            else
            begin
                write_all($urandom, ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF,
                          ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
                          8'($urandom), 4'($urandom_range(15)), {$urandom, $urandom},
                          ($urandom_range(1) == 0) ? 32'($urandom) : 32'h1111_1111 & $urandom);
            end
            quiet = (p == 3);
            // long output hold while input keeps coming
            if (p == 2)
            begin
                hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(99) < 35) ? OP_WRITE : OP_SAMPLE;
                send_item(op, 16'($urandom), 10'($urandom_range(1023)), 16'($urandom),
                          1'b0, none);
            end
        end
        quiet = 1'b0;

        settle();
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
